>>> sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assertion failed");
`endif

>>> sv/anfa_pkg.sv
// Shared types and constants of the arena allocator.
`default_nettype none
package anfa_pkg;
    localparam int HEAP_WORDS = 65536;
    localparam int ADDR_W = $clog2(HEAP_WORDS);
    localparam int POS_W = ADDR_W + 1;
    localparam int ARENA_COUNT = 5;
    localparam int MERGE_FACTOR = 32;
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [2:0] REG_A1 = 3'd0;
    localparam logic [2:0] REG_A2 = 3'd1;
    localparam logic [2:0] REG_A3 = 3'd2;
    localparam logic [2:0] REG_A4 = 3'd3;
    localparam logic [2:0] REG_SMALL = 3'd4;
    localparam logic [2:0] REG_HDR = 3'd5;
    // Marks a release in progress in place of an arena index.
    localparam logic [2:0] AR_RELEASE = 3'd7;
    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_READ, ST_EXAM, ST_MREAD, ST_MEXAM, ST_TAKE, ST_SPLIT, ST_OUT
    } state_t;
    typedef struct packed {
        logic        we;
        logic [ADDR_W-1:0] waddr;
        logic [17:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;
endpackage
`default_nettype wire

>>> sv/anfa_store.sv
// Header memory with one write and one registered read port.
`default_nettype none
module anfa_store (
    input  wire logic clk,
    input  wire anfa_pkg::mem_req_t req,
    output logic [17:0] rdata
);
    logic [17:0] mem [anfa_pkg::HEAP_WORDS];
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule
`default_nettype wire

>>> sv/arena_next_fit_block_allocator.sv
// Top level of the arena next-fit block allocator.
// Channel | direction | tdata fields (low bit first)
// s_axis  | in        | command, data_bytes, is_frame, is_int, is_code_or_class,
//         |           | saturated, release_addr
// m_axis  | out       | ok, block_addr, arena, block_words
// cfg     | in        | index, data
// A clear visits each arena in turn and then posts its result; a release reads the
// header, frees it in the split state and posts its result from the output state. An
// allocation reads each visited header and each merge probe through the single read
// port, then claims the block, splits off a large enough remainder and posts. Unknown
// commands and empty arenas answer the cycle after acceptance. Reset restores registers and cursors, not the headers.
// One item is in flight at a time; a new item is accepted once the result is taken.
`default_nettype none
`include "assert_macros.svh"
module arena_next_fit_block_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata, // command, data_bytes, is_frame, is_int,
                                           // is_code_or_class, saturated, release_addr, pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata, // ok, block_addr, arena, block_words, pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);
    localparam int AW = anfa_pkg::ADDR_W;
    localparam int PW = anfa_pkg::POS_W;
    localparam logic [PW-1:0] HEAPP = PW'(anfa_pkg::HEAP_WORDS);

    logic [16:0] a_start_reg [1:4];
    logic [15:0] small_reg;
    logic [8:0]  hdr_reg;
    logic [PW-1:0] cursor_reg [anfa_pkg::ARENA_COUNT];

    anfa_pkg::state_t state_reg, state_next;
    logic [2:0]    ar_reg, ar_next;
    logic [PW-1:0] cur_reg, cur_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [PW-1:0] nx_reg, nx_next;
    logic [16:0]   need_reg, need_next, size_reg, size_next, minf_reg, minf_next;
    logic [22:0]   limit_reg, limit_next;
    logic          wrap_reg, wrap_next;
    logic          ovalid_reg, ovalid_next;
    logic [39:0]   odata_reg, odata_next;
    logic [17:0]   rdata;
    anfa_pkg::mem_req_t req;

    anfa_store u_store (.clk(clk), .req(req), .rdata(rdata));

    function automatic logic [PW-1:0] clampv(input logic [16:0] v);
        return (v > 17'(anfa_pkg::HEAP_WORDS)) ? HEAPP : PW'(v);
    endfunction

    function automatic logic [PW-1:0] begin_of(input logic [2:0] i,
        input logic [PW-1:0] b1, input logic [PW-1:0] b2,
        input logic [PW-1:0] b3, input logic [PW-1:0] b4);
        case (i)
            3'd1: return b1;
            3'd2: return b2;
            3'd3: return b3;
            3'd4: return b4;
            3'd5: return HEAPP;
            default: return '0;
        endcase
    endfunction

    logic [PW-1:0] b1, b2, b3, b4;
    assign b1 = clampv(a_start_reg[1]);
    assign b2 = clampv(a_start_reg[2]);
    assign b3 = clampv(a_start_reg[3]);
    assign b4 = clampv(a_start_reg[4]);

    assign cfg_ready = (state_reg == anfa_pkg::ST_IDLE) && !ovalid_reg;
    assign s_axis_tready = (state_reg == anfa_pkg::ST_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;

    logic [1:0]  in_cmd;
    logic [17:0] bytes;
    logic [16:0] rsize;
    logic        rfree;
    logic [PW-1:0] stepped;
    assign in_cmd = s_axis_tdata[1:0];
    assign bytes = 18'(s_axis_tdata[17:2]) + 18'(hdr_reg);
    assign rsize = rdata[16:0];
    assign rfree = !rdata[17];
    assign stepped = cur_reg + ((rsize != 17'd0) ? rsize : 17'd1);

    logic        cur_wr;
    logic [PW-1:0] cur_wval;

    always_comb
    begin
        logic [2:0]  ar;
        logic [16:0] ncalc;
        logic [16:0] surplus;
        logic [PW-1:0] nxt;
        state_next = state_reg;
        ar_next = ar_reg;
        cur_next = cur_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        nx_next = nx_reg;
        need_next = need_reg;
        size_next = size_reg;
        minf_next = minf_reg;
        limit_next = limit_reg;
        wrap_next = wrap_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next = odata_reg;
        req = '0;
        cur_wr = 1'b0;
        cur_wval = '0;
        ar = 3'd0;
        ncalc = '0;
        surplus = '0;
        nxt = '0;
        case (state_reg)
            anfa_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    case (in_cmd)
                        anfa_pkg::CMD_CLEAR:
                        begin
                            ar_next = 3'd0;
                            state_next = anfa_pkg::ST_CLEAR;
                        end
                        anfa_pkg::CMD_ALLOC:
                        begin
                            if (s_axis_tdata[18]) ar = 3'd1;
                            else if (s_axis_tdata[19]) ar = 3'd2;
                            else if (s_axis_tdata[21] || s_axis_tdata[20]) ar = 3'd0;
                            else if (bytes < 18'(small_reg)) ar = 3'd3;
                            else ar = 3'd4;
                            ncalc = 17'((bytes + 18'd3) >> 2);
                            if (ncalc == 17'd0) ncalc = 17'd1;
                            ar_next = ar;
                            need_next = ncalc;
                            limit_next = 23'(ncalc) * 23'(anfa_pkg::MERGE_FACTOR);
                            minf_next = 17'((10'(hdr_reg) + 10'd7) >> 2);
                            lo_next = begin_of(ar, b1, b2, b3, b4);
                            hi_next = begin_of(ar + 3'd1, b1, b2, b3, b4);
                            wrap_next = 1'b0;
                            if (begin_of(ar + 3'd1, b1, b2, b3, b4) >
                                begin_of(ar, b1, b2, b3, b4))
                            begin
                                if (cursor_reg[ar] < begin_of(ar, b1, b2, b3, b4) ||
                                    cursor_reg[ar] >= begin_of(ar + 3'd1, b1, b2, b3, b4))
                                    cur_next = begin_of(ar, b1, b2, b3, b4);
                                else
                                    cur_next = cursor_reg[ar];
                                state_next = anfa_pkg::ST_READ;
                            end
                            else
                            begin
                                odata_next = {3'd0, 17'd0, ar, 16'd0, 1'b0};
                                ovalid_next = 1'b1;
                            end
                        end
                        anfa_pkg::CMD_RELEASE:
                        begin
                            cur_next = PW'(s_axis_tdata[37:22]);
                            req.raddr = s_axis_tdata[37:22];
                            state_next = anfa_pkg::ST_SPLIT;
                            ar_next = anfa_pkg::AR_RELEASE;
                        end
                        default:
                        begin
                            odata_next = '0;
                            ovalid_next = 1'b1;
                        end
                    endcase
                end
            end
            anfa_pkg::ST_CLEAR:
            begin
                lo_next = begin_of(ar_reg, b1, b2, b3, b4);
                nxt = begin_of(ar_reg + 3'd1, b1, b2, b3, b4);
                if (nxt > lo_next)
                begin
                    req.we = 1'b1;
                    req.waddr = AW'(lo_next);
                    req.wdata = {1'b0, 17'(nxt - lo_next)};
                end
                cur_wr = 1'b1;
                cur_wval = lo_next;
                if (ar_reg == 3'(anfa_pkg::ARENA_COUNT - 1))
                begin
                    odata_next = {3'd0, 17'd0, 3'd0, 16'd0, 1'b1};
                    state_next = anfa_pkg::ST_OUT;
                end
                ar_next = ar_reg + 3'd1;
            end
            anfa_pkg::ST_READ:
            begin
                req.raddr = AW'(cur_reg);
                state_next = anfa_pkg::ST_EXAM;
            end
            anfa_pkg::ST_EXAM:
            begin
                if (rfree && rsize >= need_reg)
                begin
                    size_next = rsize;
                    state_next = anfa_pkg::ST_TAKE;
                end
                else if (rfree)
                begin
                    size_next = rsize;
                    nx_next = cur_reg + rsize;
                    state_next = anfa_pkg::ST_MREAD;
                end
                else if (stepped >= hi_reg)
                begin
                    cur_next = lo_reg;
                    wrap_next = 1'b1;
                    state_next = wrap_reg ? anfa_pkg::ST_OUT : anfa_pkg::ST_READ;
                    odata_next = {3'd0, 17'd0, ar_reg, 16'd0, 1'b0};
                end
                else
                begin
                    cur_next = stepped;
                    state_next = anfa_pkg::ST_READ;
                end
            end
            anfa_pkg::ST_MREAD:
            begin
                if (nx_reg >= hi_reg || 23'(size_reg) >= limit_reg)
                    state_next = anfa_pkg::ST_MEXAM;
                else
                begin
                    req.raddr = AW'(nx_reg);
                    state_next = anfa_pkg::ST_MEXAM;
                end
            end
            anfa_pkg::ST_MEXAM:
            begin
                if (nx_reg < hi_reg && 23'(size_reg) < limit_reg && rfree &&
                    rsize != 17'd0 && (nx_reg + rsize) <= hi_reg)
                begin
                    size_next = size_reg + rsize;
                    nx_next = nx_reg + rsize;
                    state_next = anfa_pkg::ST_MREAD;
                end
                else
                begin
                    req.we = 1'b1;
                    req.waddr = AW'(cur_reg);
                    req.wdata = {1'b0, size_reg};
                    if (size_reg >= need_reg)
                        state_next = anfa_pkg::ST_TAKE;
                    else
                    begin
                        nxt = cur_reg + ((size_reg != 17'd0) ? size_reg : 17'd1);
                        if (nxt >= hi_reg)
                        begin
                            cur_next = lo_reg;
                            wrap_next = 1'b1;
                            state_next = wrap_reg ? anfa_pkg::ST_OUT : anfa_pkg::ST_READ;
                            odata_next = {3'd0, 17'd0, ar_reg, 16'd0, 1'b0};
                        end
                        else
                        begin
                            cur_next = nxt;
                            state_next = anfa_pkg::ST_READ;
                        end
                    end
                end
            end
            anfa_pkg::ST_TAKE:
            begin
                surplus = size_reg - need_reg;
                req.we = 1'b1;
                req.waddr = AW'(cur_reg);
                if (surplus < minf_reg)
                begin
                    req.wdata = {1'b1, size_reg};
                    odata_next = {3'd0, size_reg, ar_reg, AW'(cur_reg), 1'b1};
                    nxt = cur_reg + ((size_reg != 17'd0) ? size_reg : 17'd1);
                    state_next = anfa_pkg::ST_OUT;
                end
                else
                begin
                    req.wdata = {1'b1, need_reg};
                    odata_next = {3'd0, need_reg, ar_reg, AW'(cur_reg), 1'b1};
                    nxt = cur_reg + need_reg;
                    state_next = anfa_pkg::ST_SPLIT;
                end
                cur_wr = 1'b1;
                cur_wval = (nxt >= hi_reg) ? lo_reg : nxt;
            end
            anfa_pkg::ST_SPLIT:
            begin
                req.we = 1'b1;
                if (ar_reg == anfa_pkg::AR_RELEASE)
                begin
                    req.waddr = AW'(cur_reg);
                    req.wdata = {1'b0, rsize};
                    odata_next = {3'd0, 17'd0, 3'd0, AW'(cur_reg), 1'b1};
                    ar_next = 3'd0;
                end
                else
                begin
                    req.waddr = AW'(cur_reg + need_reg);
                    req.wdata = {1'b0, 17'(size_reg - need_reg)};
                end
                state_next = anfa_pkg::ST_OUT;
            end
            anfa_pkg::ST_OUT:
            begin
                ovalid_next = 1'b1;
                state_next = anfa_pkg::ST_IDLE;
            end
            default: state_next = anfa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= anfa_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
            a_start_reg[1] <= 17'd9825;
            a_start_reg[2] <= 17'd19650;
            a_start_reg[3] <= 17'd20960;
            a_start_reg[4] <= 17'd39300;
            small_reg <= 16'd1000;
            hdr_reg <= 9'd32;
            cursor_reg[0] <= '0;
            cursor_reg[1] <= PW'(9825);
            cursor_reg[2] <= PW'(19650);
            cursor_reg[3] <= PW'(20960);
            cursor_reg[4] <= PW'(39300);
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
            if (cur_wr)
            begin
                cursor_reg[ar_reg] <= cur_wval;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    anfa_pkg::REG_A1: a_start_reg[1] <= cfg_data;
                    anfa_pkg::REG_A2: a_start_reg[2] <= cfg_data;
                    anfa_pkg::REG_A3: a_start_reg[3] <= cfg_data;
                    anfa_pkg::REG_A4: a_start_reg[4] <= cfg_data;
                    anfa_pkg::REG_SMALL: small_reg <= cfg_data[15:0];
                    anfa_pkg::REG_HDR: hdr_reg <= cfg_data[8:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ar_reg <= ar_next;
        cur_reg <= cur_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        nx_reg <= nx_next;
        need_reg <= need_next;
        size_reg <= size_next;
        minf_reg <= minf_next;
        limit_reg <= limit_next;
        wrap_reg <= wrap_next;
        odata_reg <= odata_next;
    end

    `ASSERT_IMPL(a_no_accept_busy, state_reg != anfa_pkg::ST_IDLE, !s_axis_tready)
    `ASSERT_NEXT(a_out_done, state_reg == anfa_pkg::ST_OUT, m_axis_tvalid)
    `ASSERT_IMPL(a_walk_in_arena, state_reg == anfa_pkg::ST_READ,
        cur_reg >= lo_reg && cur_reg < hi_reg)
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the arena next-fit block allocator.
module testbench;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic        ok;
        logic [15:0] block_addr;
        logic [2:0]  arena;
        logic [16:0] block_words;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    arena_next_fit_block_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the allocator state.
    logic [17:0] heap_hdr [0:anfa_pkg::HEAP_WORDS-1];
    logic [16:0] next_pos [0:anfa_pkg::ARENA_COUNT-1];
    logic [16:0] start_reg [1:4];
    logic [15:0] small_limit;
    logic [8:0]  hdr_bytes;

    grant_t      expected_grants[$];
    int unsigned live_blocks[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          grants_ok = 0, grants_failed = 0, releases = 0, clears = 0, items_sent = 0;
    int          burst_left = 0;
    int          max_gap = 4;
    int          stall_mode = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver switches between always ready, random stalls and long stalls.
    always @(posedge clk)
    begin
        if (cycle_count % 97 == 0)
            stall_mode <= $urandom_range(2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(1));
            default: m_axis_tready <= ($urandom_range(5) == 0);
        endcase
    end

    function automatic int unsigned arena_lo(int i);
        int unsigned v;
        if (i == 0)
            return 0;
        v = start_reg[i];
        return (v > anfa_pkg::HEAP_WORDS) ? anfa_pkg::HEAP_WORDS : v;
    endfunction

    function automatic int unsigned arena_hi(int i);
        return (i + 1 < anfa_pkg::ARENA_COUNT) ? arena_lo(i + 1) : anfa_pkg::HEAP_WORDS;
    endfunction

    function automatic int unsigned hdr_size(int unsigned a);
        return heap_hdr[a][16:0];
    endfunction

    function automatic bit hdr_free(int unsigned a);
        return !heap_hdr[a][17];
    endfunction

    function automatic int unsigned advance(int unsigned pos, int unsigned lo,
                                            int unsigned hi, inout int wraps);
        int unsigned nx;
        nx = pos + ((hdr_size(pos) != 0) ? hdr_size(pos) : 1);
        if (nx >= hi)
        begin
            nx = lo;
            wraps++;
        end
        return nx;
    endfunction

    function automatic void absorb_free(int unsigned pos, int unsigned need, int unsigned hi);
        int unsigned total, nx, ns;
        total = hdr_size(pos);
        forever
        begin
            nx = pos + total;
            if (nx >= hi || total >= need * anfa_pkg::MERGE_FACTOR || !hdr_free(nx))
                break;
            ns = hdr_size(nx);
            if (ns == 0 || nx + ns > hi)
                break;
            total += ns;
        end
        if (total > hdr_size(pos))
            heap_hdr[pos] = {1'b0, total[16:0]};
    endfunction

    function automatic grant_t predict_grant(logic [1:0] cmd, logic [15:0] data_bytes,
                                             logic [3:0] kind, logic [15:0] rel_addr);
        grant_t g;
        int unsigned lo, hi, pos, bytes, need, minfrag, have;
        int wraps;
        g = '0;
        wraps = 0;
        if (cmd == anfa_pkg::CMD_CLEAR)
        begin
            for (int i = 0; i < anfa_pkg::ARENA_COUNT; i++)
            begin
                lo = arena_lo(i);
                hi = arena_hi(i);
                if (hi > lo)
                    heap_hdr[lo] = {1'b0, 17'(hi - lo)};
                next_pos[i] = 17'(lo);
            end
            g.ok = 1'b1;
        end
        else if (cmd == anfa_pkg::CMD_ALLOC)
        begin
            bytes = data_bytes + hdr_bytes;
            need = (bytes + 3) / 4;
            minfrag = (hdr_bytes + 7) / 4;
            if (need == 0)
                need = 1;
            // kind holds is_frame, is_int, is_code_or_class, saturated from bit 0 up.
            if (kind[0])
                g.arena = 3'd1;
            else if (kind[1])
                g.arena = 3'd2;
            else if (kind[3] || kind[2])
                g.arena = 3'd0;
            else if (bytes < small_limit)
                g.arena = 3'd3;
            else
                g.arena = 3'd4;
            lo = arena_lo(g.arena);
            hi = arena_hi(g.arena);
            if (hi > lo)
            begin
                pos = next_pos[g.arena];
                if (pos < lo || pos >= hi)
                    pos = lo;
                while (wraps <= 1)
                begin
                    if (!hdr_free(pos))
                    begin
                        pos = advance(pos, lo, hi, wraps);
                        continue;
                    end
                    if (hdr_size(pos) < need)
                    begin
                        absorb_free(pos, need, hi);
                        if (hdr_size(pos) < need)
                        begin
                            pos = advance(pos, lo, hi, wraps);
                            continue;
                        end
                    end
                    have = hdr_size(pos);
                    if (have - need < minfrag)
                    begin
                        heap_hdr[pos] = {1'b1, have[16:0]};
                        g.block_words = 17'(have);
                    end
                    else
                    begin
                        heap_hdr[pos] = {1'b1, need[16:0]};
                        heap_hdr[pos + need] = {1'b0, 17'(have - need)};
                        g.block_words = 17'(need);
                    end
                    g.ok = 1'b1;
                    g.block_addr = 16'(pos);
                    next_pos[g.arena] = 17'(advance(pos, lo, hi, wraps));
                    break;
                end
            end
        end
        else if (cmd == anfa_pkg::CMD_RELEASE)
        begin
            heap_hdr[rel_addr][17] = 1'b0;
            g.ok = 1'b1;
            g.block_addr = rel_addr;
        end
        return g;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d", field, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        grant_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[19:17],
                   m_axis_tdata[36:20]};
            if (expected_grants.size() == 0)
            begin
                $display("result with no item outstanding");
                error_count++;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (got.ok != want.ok)
                    report_mismatch("ok", got.ok, want.ok);
                if (got.block_addr != want.block_addr)
                    report_mismatch("block_addr", got.block_addr, want.block_addr);
                if (got.arena != want.arena)
                    report_mismatch("arena", got.arena, want.arena);
                if (got.block_words != want.block_words)
                    report_mismatch("block_words", got.block_words, want.block_words);
            end
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [15:0] data_bytes, logic [3:0] kind,
                             logic [15:0] rel_addr);
        grant_t g;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, max_gap);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, rel_addr, kind, data_bytes, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        g = predict_grant(cmd, data_bytes, kind, rel_addr);
        expected_grants.push_back(g);
        items_sent++;
        if (cmd == anfa_pkg::CMD_CLEAR)
        begin
            live_blocks.delete();
            clears++;
        end
        else if (cmd == anfa_pkg::CMD_RELEASE)
            releases++;
        else if (cmd == anfa_pkg::CMD_ALLOC)
        begin
            if (g.ok)
            begin
                live_blocks.push_back(g.block_addr);
                grants_ok++;
            end
            else
                grants_failed++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(int unsigned a1, int unsigned a2, int unsigned a3,
                              int unsigned a4, int unsigned small_lim, int unsigned hdr);
        logic [16:0] vals [0:5];
        logic [2:0]  regs [0:5];
        wait_drained();
        vals = '{17'(a1), 17'(a2), 17'(a3), 17'(a4), 17'(small_lim), 17'(hdr)};
        regs = '{anfa_pkg::REG_A1, anfa_pkg::REG_A2, anfa_pkg::REG_A3, anfa_pkg::REG_A4,
                 anfa_pkg::REG_SMALL, anfa_pkg::REG_HDR};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            if (i < 4)
                start_reg[i + 1] = vals[i];
            else if (i == 4)
                small_limit = vals[i][15:0];
            else
                hdr_bytes = vals[i][8:0];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        set_config(9825, 19650, 20960, 39300, 1000, 32);
        send_item(anfa_pkg::CMD_CLEAR, 16'hFFFF, 4'hF, 16'hFFFF);
        send_item(anfa_pkg::CMD_ALLOC, 0, 4'b0001, 0);
        send_item(anfa_pkg::CMD_ALLOC, 8, 4'b0010, 0);
        send_item(anfa_pkg::CMD_ALLOC, 100, 4'b1000, 0);
        send_item(anfa_pkg::CMD_ALLOC, 100, 4'b0100, 0);
        send_item(anfa_pkg::CMD_ALLOC, 10, 4'b0000, 0);
        send_item(anfa_pkg::CMD_ALLOC, 2000, 4'b0000, 0);
        send_item(anfa_pkg::CMD_ALLOC, 16'hFFFF, 4'b0000, 0);
        send_item(anfa_pkg::CMD_ALLOC, 16'hFFFF, 4'b0000, 0);
        send_item(anfa_pkg::CMD_ALLOC, 50, 4'b1111, 0);
        send_item(anfa_pkg::CMD_UNKNOWN, 16'hFFFF, 4'hF, 16'hFFFF);
        send_item(anfa_pkg::CMD_RELEASE, 0, 0, 16'(live_blocks[0]));
        send_item(anfa_pkg::CMD_RELEASE, 0, 0, 16'(live_blocks[0]));
        send_item(anfa_pkg::CMD_ALLOC, 0, 4'b0001, 0);
    endtask

    task automatic test_extreme_configs();
        set_config(0, 0, 0, 0, 0, 4);
        send_item(anfa_pkg::CMD_CLEAR, 0, 0, 0);
        send_item(anfa_pkg::CMD_ALLOC, 0, 4'b0000, 0);
        send_item(anfa_pkg::CMD_ALLOC, 0, 4'b0001, 0);
        send_item(anfa_pkg::CMD_RELEASE, 0, 0, 16'(live_blocks[0]));
        set_config(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 16'hFFFF, 256);
        send_item(anfa_pkg::CMD_CLEAR, 0, 0, 0);
        send_item(anfa_pkg::CMD_ALLOC, 16'hFFFF, 4'b0100, 0);
        send_item(anfa_pkg::CMD_ALLOC, 10, 4'b0001, 0);
        send_item(anfa_pkg::CMD_ALLOC, 10, 4'b0000, 0);
        set_config(65535, 65535, 65535, 65535, 1000, 32);
        send_item(anfa_pkg::CMD_CLEAR, 0, 0, 0);
        send_item(anfa_pkg::CMD_ALLOC, 5000, 4'b0000, 0);
        send_item(anfa_pkg::CMD_RELEASE, 0, 0, 16'hFFFF);
        send_item(anfa_pkg::CMD_ALLOC, 10, 4'b0001, 0);
    endtask

    // Tiny arenas fill up quickly, so releases force merging and wrapping.
    task automatic test_merge_and_wrap();
        set_config(100, 140, 200, 300, 64, 4);
        send_item(anfa_pkg::CMD_CLEAR, 0, 0, 0);
        repeat (12) send_item(anfa_pkg::CMD_ALLOC, 12, 4'b0001, 0);
        for (int i = 2; i < 6; i++)
            send_item(anfa_pkg::CMD_RELEASE, 0, 0, 16'(live_blocks[i]));
        send_item(anfa_pkg::CMD_ALLOC, 40, 4'b0001, 0);
        send_item(anfa_pkg::CMD_ALLOC, 4, 4'b0001, 0);
        send_item(anfa_pkg::CMD_ALLOC, 60, 4'b0001, 0);
    endtask

    task automatic random_phase(int count);
        int r;
        logic [15:0] db;
        send_item(anfa_pkg::CMD_CLEAR, 16'($urandom), 4'($urandom), 16'($urandom));
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (n == count / 2)
                wait_drained();
            if (r < 2)
                send_item(anfa_pkg::CMD_CLEAR, 16'($urandom), 4'($urandom), 16'($urandom));
            else if (r < 4)
                send_item(anfa_pkg::CMD_UNKNOWN, 16'($urandom), 4'($urandom),
                          16'($urandom));
            else if (r < 40 && live_blocks.size() != 0)
            begin
                r = $urandom_range(live_blocks.size() - 1);
                send_item(anfa_pkg::CMD_RELEASE, 16'($urandom), 4'($urandom),
                          16'(live_blocks[r]));
                if ($urandom_range(9) < 7)
                    live_blocks.delete(r);
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 80)
                    db = 16'($urandom_range(0, 200));
                else if (r < 95)
                    db = 16'($urandom_range(0, 4000));
                else
                    db = 16'($urandom);
                send_item(anfa_pkg::CMD_ALLOC, db,
                          {$urandom_range(4) == 0, $urandom_range(4) == 0,
                           $urandom_range(4) == 0, $urandom_range(4) == 0},
                          16'($urandom));
            end
        end
    endtask

    task automatic test_random();
        int unsigned s [4];
        max_gap = 0;
        set_config(9825, 19650, 20960, 39300, 1000, 32);
        random_phase(120);
        max_gap = 6;
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 4; i++)
                s[i] = (k == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 65536);
            s.sort();
            set_config(s[0], s[1], s[2], s[3], $urandom, $urandom_range(4, 256));
            random_phase(120);
        end
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_axis_tready = 1'b0;
        start_reg[1] = 9825;
        start_reg[2] = 19650;
        start_reg[3] = 20960;
        start_reg[4] = 39300;
        small_limit = 1000;
        hdr_bytes = 32;
        for (int i = 0; i < anfa_pkg::ARENA_COUNT; i++)
            next_pos[i] = 17'(arena_lo(i));
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        test_directed();
        test_extreme_configs();
        test_merge_and_wrap();
        test_random();
        wait_drained();
        repeat (64) @(posedge clk);
        $display("%0d items: %0d grants, %0d failed allocations, %0d releases, %0d clears",
                 items_sent, grants_ok, grants_failed, releases, clears);
        $display("covered arena extremes, empty arenas, merging, wrapping and unknown commands");
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/anfa_pkg.sv
sv/anfa_store.sv
sv/arena_next_fit_block_allocator.sv
tb/sv/testbench.sv
